>>> rtl/esc_pkg.sv
// Shared types and constants for the event statistics counter bank.
// Holds event kind codes, counter indexes, status codes, command and state types.
// Depends on nothing; the top level, esc_front and esc_back refer to it by scoped names.
package esc_pkg;

    localparam int NUM_COUNTERS = 18;
    localparam int IDX_W        = 5;
    localparam int KIND_W       = 5;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [KIND_W-1:0] t_kind;

    localparam logic ACTION_RECORD = 1'b0;
    localparam logic ACTION_READ   = 1'b1;

    localparam t_kind K_CONN_ACCEPT   = 5'd0;
    localparam t_kind K_CONN_CLOSE    = 5'd1;
    localparam t_kind K_CONN_ACC_ERR  = 5'd2;
    localparam t_kind K_CONN_ERR      = 5'd3;
    localparam t_kind K_CONN_TIMEOUT  = 5'd4;
    localparam t_kind K_REQ_CREATE    = 5'd5;
    localparam t_kind K_REQ_DESTROY   = 5'd6;
    localparam t_kind K_REQ_FILE      = 5'd7;
    localparam t_kind K_REQ_PROXY     = 5'd8;
    localparam t_kind K_REQ_REDIRECT  = 5'd9;
    localparam t_kind K_RESP_TIME     = 5'd10;
    localparam t_kind K_RES_2XX       = 5'd11;
    localparam t_kind K_RES_3XX       = 5'd12;
    localparam t_kind K_RES_4XX       = 5'd13;
    localparam t_kind K_RES_5XX       = 5'd14;
    localparam t_kind K_SEND_BYTES    = 5'd15;
    localparam t_kind K_RECV_BYTES    = 5'd16;

    localparam t_idx CTR_CONN_CUR     = 5'd0;
    localparam t_idx CTR_CONN_ACC     = 5'd1;
    localparam t_idx CTR_CONN_ACC_ERR = 5'd2;
    localparam t_idx CTR_CONN_ERR     = 5'd3;
    localparam t_idx CTR_CONN_TMO     = 5'd4;
    localparam t_idx CTR_REQ_CUR      = 5'd5;
    localparam t_idx CTR_REQ_TOT      = 5'd6;
    localparam t_idx CTR_REQ_FILE     = 5'd7;
    localparam t_idx CTR_REQ_PROXY    = 5'd8;
    localparam t_idx CTR_REQ_REDIR    = 5'd9;
    localparam t_idx CTR_RES_AVG      = 5'd10;
    localparam t_idx CTR_RES_PEAK     = 5'd11;
    localparam t_idx CTR_RES_2XX      = 5'd12;
    localparam t_idx CTR_RES_3XX      = 5'd13;
    localparam t_idx CTR_RES_4XX      = 5'd14;
    localparam t_idx CTR_RES_5XX      = 5'd15;
    localparam t_idx CTR_SEND         = 5'd16;
    localparam t_idx CTR_RECV         = 5'd17;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_ADD2,
        OP_SUB,
        OP_RESP,
        OP_READ,
        OP_BAD
    } t_opcode;

    typedef struct packed {
        t_opcode op;
        t_idx    idx_a;
        t_idx    idx_b;
    } t_cmd;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_RMW_A,
        BS_RMW_B,
        BS_DIV
    } t_bstate;

endpackage

>>> rtl/event_statistics_counter_bank.sv
// Top level of the event statistics counter bank.
// Ties together esc_front, esc_fifo and esc_back; uses esc_pkg for the command type.
//
// Usage: drive an item on i_action, i_event_kind, i_amount and i_counter_index
// and raise start; the beat is taken at the rising edge where start is high and
// busy is low. A record item adds, lowers or samples counters; a read item
// returns one of the 18 counters. Every item yields exactly one result beat,
// marked by o_valid for a single cycle, carrying o_value and o_status.
// Results come out in the order the items were taken.
// A single-counter record or a read is done in the back end's BS_RMW_A state;
// accept and create go on to BS_RMW_B for the second counter, and a response
// time waits in BS_DIV for the one-bit-per-cycle divider that recomputes the
// average. The back end runs one item at a time and takes no new item before it
// is through with the last; a two-entry queue lets the front accept up to two
// more items while the back end works, and busy rises when the queue is full.
// Reset clears all counters, the response-time sum and the sample count. The
// receiver cannot stall; each result must be taken as shown.
module event_statistics_counter_bank #(
    parameter int COUNTER_WIDTH = 64,
    parameter int AMOUNT_WIDTH  = 32,
    parameter int QUEUE_DEPTH   = 2
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_action,
    input  logic [4:0]               i_event_kind,
    input  logic [AMOUNT_WIDTH-1:0]  i_amount,
    input  logic [4:0]               i_counter_index,
    output logic                     o_valid,
    output logic [COUNTER_WIDTH-1:0] o_value,
    output logic [1:0]               o_status
);

    localparam int QW = $bits(esc_pkg::t_cmd) + AMOUNT_WIDTH;

    logic                    push;
    logic                    pop;
    logic                    full;
    logic                    empty;
    esc_pkg::t_cmd           front_cmd;
    logic [AMOUNT_WIDTH-1:0] front_amount;
    logic [QW-1:0]           head;
    esc_pkg::t_cmd           head_cmd;
    logic [AMOUNT_WIDTH-1:0] head_amount;

    assign head_cmd    = esc_pkg::t_cmd'(head[QW-1:AMOUNT_WIDTH]);
    assign head_amount = head[AMOUNT_WIDTH-1:0];

    esc_front #(
        .AMOUNT_WIDTH (AMOUNT_WIDTH)
    ) u_front (
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_event_kind    (i_event_kind),
        .i_amount        (i_amount),
        .i_counter_index (i_counter_index),
        .i_full          (full),
        .o_push          (push),
        .o_cmd           (front_cmd),
        .o_amount        (front_amount)
    );

    esc_fifo #(
        .DW    (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_cmd, front_amount}),
        .i_pop   (pop),
        .o_data  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    esc_back #(
        .COUNTER_WIDTH (COUNTER_WIDTH),
        .AMOUNT_WIDTH  (AMOUNT_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_head_cmd    (head_cmd),
        .i_head_amount (head_amount),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_value       (o_value),
        .o_status      (o_status)
    );

endmodule

>>> rtl/esc_front.sv
// Front end of the counter bank: accepts an item and decodes it into a command.
// Uses esc_pkg for kind codes, counter indexes and the command type.
// Pushes into the command queue; busy follows the queue's full flag.
module esc_front #(
    parameter int AMOUNT_WIDTH = 32
) (
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_action,
    input  logic [4:0]                i_event_kind,
    input  logic [AMOUNT_WIDTH-1:0]   i_amount,
    input  logic [4:0]                i_counter_index,
    input  logic                      i_full,
    output logic                      o_push,
    output esc_pkg::t_cmd             o_cmd,
    output logic [AMOUNT_WIDTH-1:0]   o_amount
);

    assign busy     = i_full;
    assign o_push   = start && !i_full;
    assign o_amount = i_amount;

    always_comb begin
        o_cmd.op    = esc_pkg::OP_BAD;
        o_cmd.idx_a = esc_pkg::CTR_CONN_CUR;
        o_cmd.idx_b = esc_pkg::CTR_CONN_CUR;
        if (i_action == esc_pkg::ACTION_READ) begin
            if (i_counter_index < esc_pkg::t_idx'(esc_pkg::NUM_COUNTERS)) begin
                o_cmd.op    = esc_pkg::OP_READ;
                o_cmd.idx_a = i_counter_index;
            end
        end else begin
            unique case (i_event_kind)
                esc_pkg::K_CONN_ACCEPT: begin
                    o_cmd.op    = esc_pkg::OP_ADD2;
                    o_cmd.idx_a = esc_pkg::CTR_CONN_CUR;
                    o_cmd.idx_b = esc_pkg::CTR_CONN_ACC;
                end
                esc_pkg::K_CONN_CLOSE: begin
                    o_cmd.op    = esc_pkg::OP_SUB;
                    o_cmd.idx_a = esc_pkg::CTR_CONN_CUR;
                end
                esc_pkg::K_CONN_ACC_ERR: begin
                    o_cmd.op    = esc_pkg::OP_ADD;
                    o_cmd.idx_a = esc_pkg::CTR_CONN_ACC_ERR;
                end
                esc_pkg::K_CONN_ERR: begin
                    o_cmd.op    = esc_pkg::OP_ADD;
                    o_cmd.idx_a = esc_pkg::CTR_CONN_ERR;
                end
                esc_pkg::K_CONN_TIMEOUT: begin
                    o_cmd.op    = esc_pkg::OP_ADD;
                    o_cmd.idx_a = esc_pkg::CTR_CONN_TMO;
                end
                esc_pkg::K_REQ_CREATE: begin
                    o_cmd.op    = esc_pkg::OP_ADD2;
                    o_cmd.idx_a = esc_pkg::CTR_REQ_TOT;
                    o_cmd.idx_b = esc_pkg::CTR_REQ_CUR;
                end
                esc_pkg::K_REQ_DESTROY: begin
                    o_cmd.op    = esc_pkg::OP_SUB;
                    o_cmd.idx_a = esc_pkg::CTR_REQ_CUR;
                end
                esc_pkg::K_REQ_FILE: begin
                    o_cmd.op    = esc_pkg::OP_ADD;
                    o_cmd.idx_a = esc_pkg::CTR_REQ_FILE;
                end
                esc_pkg::K_REQ_PROXY: begin
                    o_cmd.op    = esc_pkg::OP_ADD;
                    o_cmd.idx_a = esc_pkg::CTR_REQ_PROXY;
                end
                esc_pkg::K_REQ_REDIRECT: begin
                    o_cmd.op    = esc_pkg::OP_ADD;
                    o_cmd.idx_a = esc_pkg::CTR_REQ_REDIR;
                end
                esc_pkg::K_RESP_TIME: begin
                    o_cmd.op    = esc_pkg::OP_RESP;
                    o_cmd.idx_a = esc_pkg::CTR_RES_PEAK;
                end
                esc_pkg::K_RES_2XX: begin
                    o_cmd.op    = esc_pkg::OP_ADD;
                    o_cmd.idx_a = esc_pkg::CTR_RES_2XX;
                end
                esc_pkg::K_RES_3XX: begin
                    o_cmd.op    = esc_pkg::OP_ADD;
                    o_cmd.idx_a = esc_pkg::CTR_RES_3XX;
                end
                esc_pkg::K_RES_4XX: begin
                    o_cmd.op    = esc_pkg::OP_ADD;
                    o_cmd.idx_a = esc_pkg::CTR_RES_4XX;
                end
                esc_pkg::K_RES_5XX: begin
                    o_cmd.op    = esc_pkg::OP_ADD;
                    o_cmd.idx_a = esc_pkg::CTR_RES_5XX;
                end
                esc_pkg::K_SEND_BYTES: begin
                    o_cmd.op    = esc_pkg::OP_ADD;
                    o_cmd.idx_a = esc_pkg::CTR_SEND;
                end
                esc_pkg::K_RECV_BYTES: begin
                    o_cmd.op    = esc_pkg::OP_ADD;
                    o_cmd.idx_a = esc_pkg::CTR_RECV;
                end
                default: begin
                    o_cmd.op = esc_pkg::OP_BAD;
                end
            endcase
        end
    end

endmodule

>>> rtl/esc_fifo.sv
// Short command queue between the front end and the execution back end.
// Generic width and depth; depends on nothing else.
module esc_fifo #(
    parameter int DW    = 45,
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output logic          o_full,
    output logic          o_empty
);

    localparam int PW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [DW-1:0]   r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CNTW-1:0] r_count;
    logic [PW-1:0]   n_wp;
    logic [PW-1:0]   n_rp;
    logic [CNTW-1:0] n_count;

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_count = r_count;
        if (i_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CNTW'(DEPTH)))
        else $error("command queue holds more entries than its depth");

endmodule

>>> rtl/esc_div.sv
// Restoring divider, one quotient bit per cycle, for the average response time.
// Generic width; depends on nothing else.
module esc_div #(
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quotient
);

    localparam int CNTW = $clog2(W + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [W-1:0]    r_rem;
    logic [W-1:0]    r_quo;
    logic [W-1:0]    r_dvs;
    logic [W:0]      shifted;
    logic [W:0]      diff;
    logic            ge;
    logic [W-1:0]    n_rem;

    assign shifted    = {r_rem, r_quo[W-1]};
    assign diff       = shifted - {1'b0, r_dvs};
    assign ge         = (shifted >= {1'b0, r_dvs});
    assign n_rem      = ge ? diff[W-1:0] : shifted[W-1:0];
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNTW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[W-2:0], ge};
        end
    end

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy))
        else $error("divider signals done without having run");

endmodule

>>> rtl/esc_back.sv
// Back end of the counter bank: executes queued commands on the counter memory.
// Uses esc_pkg for commands, states and codes, and esc_div for the average.
// Drives the registered result strobe, value and status.
module esc_back #(
    parameter int COUNTER_WIDTH = 64,
    parameter int AMOUNT_WIDTH  = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_empty,
    input  esc_pkg::t_cmd            i_head_cmd,
    input  logic [AMOUNT_WIDTH-1:0]  i_head_amount,
    output logic                     o_pop,
    output logic                     o_valid,
    output logic [COUNTER_WIDTH-1:0] o_value,
    output logic [1:0]               o_status
);

    localparam int CW = COUNTER_WIDTH;
    localparam int MW = (AMOUNT_WIDTH > COUNTER_WIDTH) ? AMOUNT_WIDTH : COUNTER_WIDTH;

    esc_pkg::t_bstate           r_state;
    esc_pkg::t_bstate           n_state;
    esc_pkg::t_cmd              r_cmd;
    esc_pkg::t_cmd              n_cmd;
    logic [AMOUNT_WIDTH-1:0]    r_amt;
    logic [AMOUNT_WIDTH-1:0]    n_amt;
    logic [CW-1:0]              r_tsum;
    logic [CW-1:0]              n_tsum;
    logic [CW-1:0]              r_cnt;
    logic [CW-1:0]              n_cnt;
    logic [CW-1:0]              r_mem [esc_pkg::NUM_COUNTERS];
    logic [esc_pkg::NUM_COUNTERS-1:0] r_vld;
    logic [CW-1:0]              r_rdata;
    logic                       r_rvld;
    logic                       r_ovalid;
    logic                       n_ovalid;
    logic [CW-1:0]              r_ovalue;
    logic [CW-1:0]              n_ovalue;
    logic [1:0]                 r_ostatus;
    logic [1:0]                 n_ostatus;

    logic                       we;
    esc_pkg::t_idx              wa;
    logic [CW-1:0]              wd;
    esc_pkg::t_idx              ra;
    logic [CW-1:0]              rd;
    logic [MW-1:0]              amt_x;
    logic [MW-1:0]              rd_x;
    logic [MW-1:0]              cmax_x;
    logic [CW-1:0]              sum;
    logic [CW-1:0]              diff;
    logic                       under;
    logic [CW-1:0]              cand;
    logic                       div_start;
    logic                       div_done;
    logic [CW-1:0]              div_quo;

    assign rd     = r_rvld ? r_rdata : '0;
    assign amt_x  = MW'(r_amt);
    assign rd_x   = MW'(rd);
    assign cmax_x = MW'({CW{1'b1}});
    assign sum    = CW'(rd_x + amt_x);
    assign diff   = CW'(rd_x - amt_x);
    assign under  = (amt_x > rd_x);
    assign cand   = (amt_x > cmax_x) ? {CW{1'b1}} : CW'(r_amt);

    assign o_valid  = r_ovalid;
    assign o_value  = r_ovalue;
    assign o_status = r_ostatus;

    esc_div #(
        .W (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_tsum),
        .i_divisor  (n_cnt),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_amt     = r_amt;
        n_tsum    = r_tsum;
        n_cnt     = r_cnt;
        o_pop     = 1'b0;
        we        = 1'b0;
        wa        = r_cmd.idx_a;
        wd        = sum;
        ra        = i_head_cmd.idx_a;
        div_start = 1'b0;
        n_ovalid  = 1'b0;
        n_ovalue  = '0;
        n_ostatus = esc_pkg::ST_OK;
        unique case (r_state)
            esc_pkg::BS_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_head_cmd;
                    n_amt   = i_head_amount;
                    n_state = esc_pkg::BS_RMW_A;
                end
            end
            esc_pkg::BS_RMW_A: begin
                unique case (r_cmd.op)
                    esc_pkg::OP_ADD: begin
                        we       = 1'b1;
                        n_ovalid = 1'b1;
                        n_state  = esc_pkg::BS_IDLE;
                    end
                    esc_pkg::OP_ADD2: begin
                        we      = 1'b1;
                        ra      = r_cmd.idx_b;
                        n_state = esc_pkg::BS_RMW_B;
                    end
                    esc_pkg::OP_SUB: begin
                        we        = 1'b1;
                        wd        = under ? '0 : diff;
                        n_ovalid  = 1'b1;
                        n_ostatus = under ? esc_pkg::ST_UNDERFLOW : esc_pkg::ST_OK;
                        n_state   = esc_pkg::BS_IDLE;
                    end
                    esc_pkg::OP_READ: begin
                        n_ovalid = 1'b1;
                        n_ovalue = rd;
                        n_state  = esc_pkg::BS_IDLE;
                    end
                    esc_pkg::OP_RESP: begin
                        n_tsum    = CW'(MW'(r_tsum) + amt_x);
                        n_cnt     = r_cnt + 1'b1;
                        div_start = 1'b1;
                        we        = (rd < cand);
                        wd        = cand;
                        n_state   = esc_pkg::BS_DIV;
                    end
                    default: begin
                        n_ovalid  = 1'b1;
                        n_ostatus = esc_pkg::ST_INVALID;
                        n_state   = esc_pkg::BS_IDLE;
                    end
                endcase
            end
            esc_pkg::BS_RMW_B: begin
                we       = 1'b1;
                wa       = r_cmd.idx_b;
                n_ovalid = 1'b1;
                n_state  = esc_pkg::BS_IDLE;
            end
            esc_pkg::BS_DIV: begin
                if (div_done) begin
                    we       = 1'b1;
                    wa       = esc_pkg::CTR_RES_AVG;
                    wd       = (r_cnt == '0) ? '0 : div_quo;
                    n_ovalid = 1'b1;
                    n_state  = esc_pkg::BS_IDLE;
                end
            end
            default: begin
                n_state = esc_pkg::BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= esc_pkg::BS_IDLE;
            r_tsum   <= '0;
            r_cnt    <= '0;
            r_vld    <= '0;
            r_rvld   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tsum   <= n_tsum;
            r_cnt    <= n_cnt;
            r_rvld   <= r_vld[ra];
            r_ovalid <= n_ovalid;
            if (we) begin
                r_vld[wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_amt     <= n_amt;
        r_ovalue  <= n_ovalue;
        r_ostatus <= n_ostatus;
        r_rdata   <= r_mem[ra];
        if (we) begin
            r_mem[wa] <= wd;
        end
    end

    a_second_after_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == esc_pkg::BS_RMW_B) |-> ($past(r_state) == esc_pkg::BS_RMW_A))
        else $error("second counter update without a first one");

    a_fault_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ostatus != esc_pkg::ST_OK) |-> (r_ovalue == '0))
        else $error("nonzero value reported with an error status");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == esc_pkg::BS_IDLE && !i_empty))
        else $error("queue popped outside the idle state");

endmodule
